[hdl/fkin_pkg.sv]
// shared types, constants and helper functions for the arm kinematics core
// no dependencies
`default_nettype none
package fkin_pkg;

  localparam int CORDIC_ITERATIONS_DEF = 16;
  localparam int ATAN_DEPTH = 24;

  localparam int AngW   = 35;   // residual angle, Q2.30 with headroom
  localparam int TrigW  = 34;   // sine / cosine, Q2.30 with headroom
  localparam int RW     = 35;   // radius, Q.30
  localparam int ProdW  = 53;   // 35 x 18 product
  localparam int AccW   = 68;
  localparam int PosW   = 20;
  localparam int LenW   = 16;
  localparam int JntW   = 16;
  localparam int RegIdxW = 3;

  localparam logic signed [JntW-1:0] BASE_LIMIT = 16'sd25736;
  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [TrigW-1:0] GAIN_Q30 = 34'sd652032874;

  localparam logic signed [PosW-1:0] POS_MAX = 20'sd524287;
  localparam logic signed [PosW-1:0] POS_MIN = -20'sd524288;
  localparam logic signed [PosW-1:0] POSE_X_RST = 20'sd19661;
  localparam logic signed [PosW-1:0] POSE_Y_RST = 20'sd0;
  localparam logic signed [PosW-1:0] POSE_Z_RST = 20'sd19661;

  // configuration register indexes
  localparam logic [RegIdxW-1:0] REG_UPPER_LEN = 3'd0;
  localparam logic [RegIdxW-1:0] REG_FORE_LEN  = 3'd1;
  localparam logic [RegIdxW-1:0] REG_SH_MIN    = 3'd2;
  localparam logic [RegIdxW-1:0] REG_SH_MAX    = 3'd3;
  localparam logic [RegIdxW-1:0] REG_EL_MIN    = 3'd4;
  localparam logic [RegIdxW-1:0] REG_EL_MAX    = 3'd5;
  localparam logic [RegIdxW-1:0] REG_WR_MIN    = 3'd6;
  localparam logic [RegIdxW-1:0] REG_WR_MAX    = 3'd7;

  // which angle travels down the rotator chain
  localparam logic [1:0] TAG_SHOULDER = 2'd0;
  localparam logic [1:0] TAG_SUM      = 2'd1;
  localparam logic [1:0] TAG_BASE     = 2'd2;

  localparam logic signed [AngW-1:0] ATAN_TAB [ATAN_DEPTH] = '{
    35'sh03243F6A8, 35'sh01DAC6705, 35'sh00FADBAFC, 35'sh007F56EA6,
    35'sh003FEAB76, 35'sh001FFD55B, 35'sh000FFFAAA, 35'sh0007FFF55,
    35'sh0003FFFEA, 35'sh0001FFFFD, 35'sh0000FFFFF, 35'sh00007FFFF,
    35'sh00003FFFF, 35'sh00001FFFF, 35'sh00000FFFF, 35'sh000007FFF,
    35'sh000003FFF, 35'sh000001FFF, 35'sh000000FFF, 35'sh0000007FF,
    35'sh0000003FF, 35'sh0000001FF, 35'sh0000000FF, 35'sh00000007F
  };

  typedef struct packed {
    logic                    valid;
    logic [1:0]              tag;
    logic                    neg;
    logic signed [TrigW-1:0] x;
    logic signed [TrigW-1:0] y;
    logic signed [AngW-1:0]  a;
  } cordic_stage_t;

  typedef struct packed {
    logic neg;
    logic signed [AngW-1:0] a;
  } prep_t;

  // reduce a Q3.13 angle into [-pi/2, pi/2] in Q2.30, flag for negation
  function automatic prep_t prep_angle(input logic signed [JntW:0] ang);
    logic signed [35:0] a;
    prep_t res;
    a = 36'(ang) <<< 17;
    if (a > PI_Q30) begin
      a = a - TWO_PI_Q30;
    end else if (a < -PI_Q30) begin
      a = a + TWO_PI_Q30;
    end
    res.neg = 1'b0;
    if (a > HALF_PI_Q30) begin
      a = a - PI_Q30;
      res.neg = 1'b1;
    end else if (a < -HALF_PI_Q30) begin
      a = a + PI_Q30;
      res.neg = 1'b1;
    end
    res.a = a[AngW-1:0];
    return res;
  endfunction

  function automatic logic signed [PosW-1:0] sat20(input logic signed [AccW-1:0] v);
    if (v > AccW'(POS_MAX)) begin
      return POS_MAX;
    end else if (v < AccW'(POS_MIN)) begin
      return POS_MIN;
    end
    return v[PosW-1:0];
  endfunction

endpackage
`default_nettype wire

[hdl/arm_joint_limit_forward_kinematics_core.sv]
// response: a rejected request answers in the cycle after acceptance; an accepted one
// passes feed, the CORDIC_ITERATIONS-step rotator chain (16 by default), mac and output
// throughput: one request at a time, which passes the rotator chain and then the
// ten-step multiply sequence; rejections can go every cycle while no result is stalled
// reset: synchronous active-low, restores lengths, limit registers and the 0.3 m pose
// top level of the arm kinematics core; depends on fkin_pkg, fkin_cordic_cell, fkin_mac
`default_nettype none
module arm_joint_limit_forward_kinematics_core #(
  parameter int CORDIC_ITERATIONS = fkin_pkg::CORDIC_ITERATIONS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // request channel
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire signed [fkin_pkg::JntW-1:0]      in_base_angle,
  input  wire signed [fkin_pkg::JntW-1:0]      in_shoulder_angle,
  input  wire signed [fkin_pkg::JntW-1:0]      in_elbow_angle,
  input  wire signed [fkin_pkg::JntW-1:0]      in_wrist_roll_angle,
  // result channel
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic                                 out_accepted,
  output logic signed [fkin_pkg::PosW-1:0]     out_pos_x,
  output logic signed [fkin_pkg::PosW-1:0]     out_pos_y,
  output logic signed [fkin_pkg::PosW-1:0]     out_pos_z,
  // configuration writes
  input  wire                                  cfg_wr_en,
  input  wire        [fkin_pkg::RegIdxW-1:0]   cfg_addr,
  input  wire        [15:0]                    cfg_wdata
);

  localparam int JntW = fkin_pkg::JntW;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_FEED = 5'b00010,
    ST_WAIT = 5'b00100,
    ST_MAC  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic        [15:0]     l1_r, l2_r;
  logic signed [JntW-1:0] sh_min_r, sh_max_r, el_min_r, el_max_r, wr_min_r, wr_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_r     <= 16'd6554;
      l2_r     <= 16'd6554;
      sh_min_r <= -16'sd12868;
      sh_max_r <= 16'sd12868;
      el_min_r <= -16'sd12868;
      el_max_r <= 16'sd12868;
      wr_min_r <= -16'sd25736;
      wr_max_r <= 16'sd25736;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        fkin_pkg::REG_UPPER_LEN: l1_r     <= cfg_wdata;
        fkin_pkg::REG_FORE_LEN:  l2_r     <= cfg_wdata;
        fkin_pkg::REG_SH_MIN:    sh_min_r <= cfg_wdata;
        fkin_pkg::REG_SH_MAX:    sh_max_r <= cfg_wdata;
        fkin_pkg::REG_EL_MIN:    el_min_r <= cfg_wdata;
        fkin_pkg::REG_EL_MAX:    el_max_r <= cfg_wdata;
        fkin_pkg::REG_WR_MIN:    wr_min_r <= cfg_wdata;
        fkin_pkg::REG_WR_MAX:    wr_max_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // handshake; a request is taken only once a waiting result can move
  logic in_acc;
  logic lim_ok;
  assign in_stall = (state_r != ST_IDLE) || (out_valid && out_stall);
  assign in_acc   = in_valid && !in_stall;

  // joint limit window check, base is fixed to +-pi
  assign lim_ok = (in_base_angle >= -fkin_pkg::BASE_LIMIT)
               && (in_base_angle <= fkin_pkg::BASE_LIMIT)
               && (in_shoulder_angle >= sh_min_r) && (in_shoulder_angle <= sh_max_r)
               && (in_elbow_angle >= el_min_r) && (in_elbow_angle <= el_max_r)
               && (in_wrist_roll_angle >= wr_min_r) && (in_wrist_roll_angle <= wr_max_r);

  // latched joint angles for the three rotator passes
  logic signed [JntW:0] b_r, b_nxt, s_r, s_nxt, sum_r, sum_nxt;
  logic [1:0]           feed_r, feed_nxt;

  // rotator chain
  fkin_pkg::cordic_stage_t chain [CORDIC_ITERATIONS+1];
  fkin_pkg::cordic_stage_t head;
  fkin_pkg::prep_t         prep;
  logic signed [JntW:0]    feed_ang;

  always_comb begin
    case (feed_r)
      fkin_pkg::TAG_SHOULDER: feed_ang = s_r;
      fkin_pkg::TAG_SUM:      feed_ang = sum_r;
      default:                feed_ang = b_r;
    endcase
    prep       = fkin_pkg::prep_angle(feed_ang);
    head.valid = (state_r == ST_FEED);
    head.tag   = feed_r;
    head.neg   = prep.neg;
    head.x     = fkin_pkg::GAIN_Q30;
    head.y     = '0;
    head.a     = prep.a;
  end

  assign chain[0] = head;

  for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_cell
    fkin_cordic_cell #(.SHIFT(i)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_in  (chain[i]),
      .stage_out (chain[i+1])
    );
  end

  // capture sines and cosines as they leave the chain, undo the half-turn fold
  fkin_pkg::cordic_stage_t         tail;
  logic signed [fkin_pkg::TrigW-1:0] tc, ts;
  logic signed [fkin_pkg::TrigW-1:0] cs_r, ss_r, cse_r, sse_r, cb_r, sb_r;

  assign tail = chain[CORDIC_ITERATIONS];
  assign tc   = tail.neg ? -tail.x : tail.x;
  assign ts   = tail.neg ? -tail.y : tail.y;

  always_ff @(posedge clk) begin
    if (tail.valid) begin
      case (tail.tag)
        fkin_pkg::TAG_SHOULDER: begin cs_r  <= tc; ss_r  <= ts; end
        fkin_pkg::TAG_SUM:      begin cse_r <= tc; sse_r <= ts; end
        default:                begin cb_r  <= tc; sb_r  <= ts; end
      endcase
    end
  end

  // multiply sequence
  logic mac_start_r, mac_start_nxt;
  logic mac_done;
  logic signed [fkin_pkg::PosW-1:0] mac_x, mac_y, mac_z;

  fkin_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mac_start_r),
    .l1    (l1_r),
    .l2    (l2_r),
    .cs    (cs_r),
    .ss    (ss_r),
    .cse   (cse_r),
    .sse   (sse_r),
    .cb    (cb_r),
    .sb    (sb_r),
    .done  (mac_done),
    .pos_x (mac_x),
    .pos_y (mac_y),
    .pos_z (mac_z)
  );

  // stored pose and output register
  logic signed [fkin_pkg::PosW-1:0] pose_x_r, pose_x_nxt, pose_y_r, pose_y_nxt;
  logic signed [fkin_pkg::PosW-1:0] pose_z_r, pose_z_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic                             out_acc_r, out_acc_nxt;
  logic signed [fkin_pkg::PosW-1:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic signed [fkin_pkg::PosW-1:0] out_z_r, out_z_nxt;

  always_comb begin
    state_nxt     = state_r;
    feed_nxt      = feed_r;
    b_nxt         = b_r;
    s_nxt         = s_r;
    sum_nxt       = sum_r;
    mac_start_nxt = 1'b0;
    pose_x_nxt    = pose_x_r;
    pose_y_nxt    = pose_y_r;
    pose_z_nxt    = pose_z_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_acc_nxt   = out_acc_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_z_nxt     = out_z_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (lim_ok) begin
            state_nxt = ST_FEED;
            feed_nxt  = fkin_pkg::TAG_SHOULDER;
            b_nxt     = (JntW+1)'(in_base_angle);
            s_nxt     = (JntW+1)'(in_shoulder_angle);
            sum_nxt   = (JntW+1)'(in_shoulder_angle) + (JntW+1)'(in_elbow_angle);
          end else begin
            // out of limits: answer at once with the old pose
            out_valid_nxt = 1'b1;
            out_acc_nxt   = 1'b0;
            out_x_nxt     = pose_x_r;
            out_y_nxt     = pose_y_r;
            out_z_nxt     = pose_z_r;
          end
        end
      end
      ST_FEED: begin
        feed_nxt = feed_r + 2'd1;
        if (feed_r == fkin_pkg::TAG_BASE) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (tail.valid && tail.tag == fkin_pkg::TAG_BASE) begin
          state_nxt     = ST_MAC;
          mac_start_nxt = 1'b1;
        end
      end
      ST_MAC: begin
        if (mac_done) begin
          state_nxt  = ST_OUT;
          pose_x_nxt = mac_x;
          pose_y_nxt = mac_y;
          pose_z_nxt = mac_z;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_acc_nxt   = 1'b1;
          out_x_nxt     = pose_x_r;
          out_y_nxt     = pose_y_r;
          out_z_nxt     = pose_z_r;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      feed_r      <= fkin_pkg::TAG_SHOULDER;
      mac_start_r <= 1'b0;
      out_valid_r <= 1'b0;
      pose_x_r    <= fkin_pkg::POSE_X_RST;
      pose_y_r    <= fkin_pkg::POSE_Y_RST;
      pose_z_r    <= fkin_pkg::POSE_Z_RST;
    end else begin
      state_r     <= state_nxt;
      feed_r      <= feed_nxt;
      mac_start_r <= mac_start_nxt;
      out_valid_r <= out_valid_nxt;
      pose_x_r    <= pose_x_nxt;
      pose_y_r    <= pose_y_nxt;
      pose_z_r    <= pose_z_nxt;
    end
    b_r       <= b_nxt;
    s_r       <= s_nxt;
    sum_r     <= sum_nxt;
    out_acc_r <= out_acc_nxt;
    out_x_r   <= out_x_nxt;
    out_y_r   <= out_y_nxt;
    out_z_r   <= out_z_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_accepted = out_acc_r;
  assign out_pos_x    = out_x_r;
  assign out_pos_y    = out_y_r;
  assign out_pos_z    = out_z_r;

endmodule
`default_nettype wire

[hdl/fkin_cordic_cell.sv]
// one rotation step of the cordic chain, registered
// depends on fkin_pkg
`default_nettype none
module fkin_cordic_cell #(
  parameter int SHIFT = 0
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  fkin_pkg::cordic_stage_t  stage_in,
  output fkin_pkg::cordic_stage_t  stage_out
);

  fkin_pkg::cordic_stage_t stage_r, stage_nxt;

  always_comb begin
    stage_nxt = stage_in;
    if (!stage_in.a[fkin_pkg::AngW-1]) begin
      stage_nxt.x = stage_in.x - (stage_in.y >>> SHIFT);
      stage_nxt.y = stage_in.y + (stage_in.x >>> SHIFT);
      stage_nxt.a = stage_in.a - fkin_pkg::ATAN_TAB[SHIFT];
    end else begin
      stage_nxt.x = stage_in.x + (stage_in.y >>> SHIFT);
      stage_nxt.y = stage_in.y - (stage_in.x >>> SHIFT);
      stage_nxt.a = stage_in.a + fkin_pkg::ATAN_TAB[SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else begin
      stage_r.valid <= stage_nxt.valid;
    end
    stage_r.tag <= stage_nxt.tag;
    stage_r.neg <= stage_nxt.neg;
    stage_r.x   <= stage_nxt.x;
    stage_r.y   <= stage_nxt.y;
    stage_r.a   <= stage_nxt.a;
  end

  assign stage_out = stage_r;

endmodule
`default_nettype wire

[hdl/fkin_mac.sv]
// multiply-accumulate sequencer: link terms, radius, then z, x, y
// depends on fkin_pkg
`default_nettype none
module fkin_mac (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    start,
  input  wire        [fkin_pkg::LenW-1:0]        l1,
  input  wire        [fkin_pkg::LenW-1:0]        l2,
  input  wire signed [fkin_pkg::TrigW-1:0]       cs,
  input  wire signed [fkin_pkg::TrigW-1:0]       ss,
  input  wire signed [fkin_pkg::TrigW-1:0]       cse,
  input  wire signed [fkin_pkg::TrigW-1:0]       sse,
  input  wire signed [fkin_pkg::TrigW-1:0]       cb,
  input  wire signed [fkin_pkg::TrigW-1:0]       sb,
  output logic                                   done,
  output logic signed [fkin_pkg::PosW-1:0]       pos_x,
  output logic signed [fkin_pkg::PosW-1:0]       pos_y,
  output logic signed [fkin_pkg::PosW-1:0]       pos_z
);

  localparam int AccW = fkin_pkg::AccW;
  localparam logic signed [AccW-1:0] HALF15 = AccW'(1) <<< 14;
  localparam logic signed [AccW-1:0] HALF29 = AccW'(1) <<< 28;
  localparam logic signed [AccW-1:0] HALF44 = AccW'(1) <<< 43;
  localparam logic [3:0] LAST_STEP = 4'd9;

  logic        busy_r, busy_nxt;
  logic [3:0]  stp_r, stp_nxt;
  logic        done_r, done_nxt;
  logic signed [fkin_pkg::ProdW-1:0] prod_r, prod_nxt;
  logic signed [AccW-1:0]            acc_r, acc_nxt;
  logic signed [fkin_pkg::RW-1:0]    r_r, r_nxt;
  logic signed [fkin_pkg::PosW-1:0]  x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic signed [fkin_pkg::RW-1:0]    op_a;
  logic signed [17:0]                op_b;
  logic signed [AccW-1:0]            prod_ext, acc_rnd;

  // operand select for the shared multiplier
  always_comb begin
    case (stp_r[2:0])
      3'd0:    begin op_a = fkin_pkg::RW'(cs);  op_b = {2'b00, l1}; end
      3'd1:    begin op_a = fkin_pkg::RW'(cse); op_b = {2'b00, l2}; end
      3'd2:    begin op_a = fkin_pkg::RW'(ss);  op_b = {2'b00, l1}; end
      3'd3:    begin op_a = fkin_pkg::RW'(sse); op_b = {2'b00, l2}; end
      3'd4:    begin op_a = r_r; op_b = cb[fkin_pkg::TrigW-1:16]; end
      3'd5:    begin op_a = r_r; op_b = {2'b00, cb[15:0]}; end
      3'd6:    begin op_a = r_r; op_b = sb[fkin_pkg::TrigW-1:16]; end
      default: begin op_a = r_r; op_b = {2'b00, sb[15:0]}; end
    endcase
  end

  always_comb begin
    prod_ext = AccW'(prod_r);
    prod_nxt = fkin_pkg::ProdW'(op_a) * fkin_pkg::ProdW'(op_b);
    busy_nxt = busy_r;
    stp_nxt  = stp_r;
    done_nxt = 1'b0;
    acc_nxt  = acc_r;
    r_nxt    = r_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    acc_rnd  = '0;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        stp_nxt  = '0;
      end
    end else begin
      stp_nxt = stp_r + 4'd1;
      case (stp_r)
        4'd1: acc_nxt = prod_ext;
        4'd2, 4'd4, 4'd6, 4'd8: acc_nxt = acc_r + prod_ext;
        4'd3: begin
          acc_rnd = (acc_r + HALF15) >>> 15;
          r_nxt   = acc_rnd[fkin_pkg::RW-1:0];
          acc_nxt = prod_ext;
        end
        4'd5: begin
          acc_rnd = (acc_r + HALF29) >>> 29;
          z_nxt   = fkin_pkg::sat20(acc_rnd);
          acc_nxt = prod_ext <<< 16;
        end
        4'd7: begin
          acc_rnd = (acc_r + HALF44) >>> 44;
          x_nxt   = fkin_pkg::sat20(acc_rnd);
          acc_nxt = prod_ext <<< 16;
        end
        LAST_STEP: begin
          acc_rnd  = (acc_r + HALF44) >>> 44;
          y_nxt    = fkin_pkg::sat20(acc_rnd);
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      stp_r  <= '0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      stp_r  <= stp_nxt;
      done_r <= done_nxt;
    end
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    r_r    <= r_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
  end

  assign done  = done_r;
  assign pos_x = x_r;
  assign pos_y = y_r;
  assign pos_z = z_r;

endmodule
`default_nettype wire

[hdl/fkin_checker.sv]
// port-level checks for the arm kinematics core, bound to the top level
// depends on fkin_pkg
`default_nettype none
module fkin_checker (
  input wire                                  clk,
  input wire                                  rst_n,
  input wire                                  in_valid,
  input wire                                  in_stall,
  input wire                                  out_valid,
  input wire                                  out_stall,
  input wire                                  out_accepted,
  input wire signed [fkin_pkg::PosW-1:0]      out_pos_x,
  input wire signed [fkin_pkg::PosW-1:0]      out_pos_y,
  input wire signed [fkin_pkg::PosW-1:0]      out_pos_z
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pos_x) && $stable(out_pos_y)
      && $stable(out_pos_z) && $stable(out_accepted))
    else $error("stalled result changed");

  // no request is taken while a result is blocked
  a_no_take_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> !(out_valid && out_stall))
    else $error("request taken while result blocked");

  // reset empties the result register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind arm_joint_limit_forward_kinematics_core fkin_checker u_fkin_checker (.*);
`default_nettype wire
